### sv/lfc_pkg.sv
// Shared constants, types and table functions for the two-channel lux calculator.
package lfc_pkg;

    localparam int RATIO_FRAC_BITS  = 9;
    localparam int LUX_FRAC_BITS    = 14;
    localparam int TABLE_RATIO_BITS = 9;
    localparam int TABLE_LUX_BITS   = 14;
    localparam int SEGMENTS         = 8;
    localparam int SEG_W            = $clog2(SEGMENTS);

    localparam int COUNT_W = 16;
    localparam int LUX_W   = 16;

    // dividend is infrared << (RATIO_FRAC_BITS + 1); one quotient bit per stage
    localparam int DIV_W  = COUNT_W + RATIO_FRAC_BITS + 1;
    localparam int CMP_W  = DIV_W + TABLE_RATIO_BITS;

    localparam int TBL_W    = 10;
    localparam int COEF_SHL = (LUX_FRAC_BITS >= TABLE_LUX_BITS) ?
                              (LUX_FRAC_BITS - TABLE_LUX_BITS) : 0;
    localparam int COEF_SHR = (LUX_FRAC_BITS >= TABLE_LUX_BITS) ?
                              0 : (TABLE_LUX_BITS - LUX_FRAC_BITS);
    localparam int COEF_W   = TBL_W + COEF_SHL;
    localparam int PROD_W   = COUNT_W + COEF_W;
    localparam int SUM_W    = PROD_W + 1;

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [LUX_W-1:0]   t_lux;
    typedef logic [DIV_W-1:0]   t_quot;
    typedef logic [TBL_W-1:0]   t_tbl;
    typedef logic [COEF_W-1:0]  t_coef;
    typedef logic [PROD_W-1:0]  t_prod;
    typedef logic [SEG_W-1:0]   t_seg;

    // breakpoints (9 fraction bits), intercepts and slopes (14 fraction bits)
    localparam t_tbl SEG_K [SEGMENTS] = '{
        10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a, 10'h29a
    };
    localparam t_tbl SEG_B [SEGMENTS] = '{
        10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000
    };
    localparam t_tbl SEG_M [SEGMENTS] = '{
        10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000
    };

    function automatic t_coef scale_coeff(input t_tbl c);
        t_coef w;
        w = t_coef'(c);
        return (w << COEF_SHL) >> COEF_SHR;
    endfunction

    // first segment whose breakpoint is not below the ratio
    function automatic t_seg pick_segment(input t_quot ratio);
        logic [CMP_W-1:0] lhs;
        t_seg             seg;
        lhs = CMP_W'(ratio) << TABLE_RATIO_BITS;
        seg = SEG_W'(SEGMENTS - 1);
        for (int i = SEGMENTS - 2; i >= 0; i--) begin
            if (lhs <= (CMP_W'(SEG_K[i]) << RATIO_FRAC_BITS)) begin
                seg = SEG_W'(i);
            end
        end
        return seg;
    endfunction

endpackage

### sv/lfc_div.sv
// Pipelined restoring divider: (infrared << (RATIO_FRAC_BITS+1)) / broadband.
module lfc_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  lfc_pkg::t_count      i_bb,
    input  lfc_pkg::t_count      i_ir,
    output logic                 o_valid,
    output lfc_pkg::t_quot       o_quot,
    output lfc_pkg::t_count      o_bb,
    output lfc_pkg::t_count      o_ir
);

    localparam int N = lfc_pkg::DIV_W;

    logic                 w_vld  [N+1];
    lfc_pkg::t_count      w_rem  [N+1];
    lfc_pkg::t_quot       w_work [N+1];
    lfc_pkg::t_count      w_bb   [N+1];
    lfc_pkg::t_count      w_ir   [N+1];

    assign w_vld[0]  = i_valid;
    assign w_rem[0]  = '0;
    assign w_work[0] = {i_ir, {(lfc_pkg::RATIO_FRAC_BITS + 1){1'b0}}};
    assign w_bb[0]   = i_bb;
    assign w_ir[0]   = i_ir;

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic                      r_vld;
        lfc_pkg::t_count           r_rem;
        lfc_pkg::t_quot            r_work;
        lfc_pkg::t_count           r_bb;
        lfc_pkg::t_count           r_ir;
        logic [lfc_pkg::COUNT_W:0] trial;
        logic [lfc_pkg::COUNT_W:0] diff;
        logic                      ge;
        lfc_pkg::t_count           n_rem;
        lfc_pkg::t_quot            n_work;

        always_comb begin
            trial  = {w_rem[k], w_work[k][N-1]};
            diff   = trial - {1'b0, w_bb[k]};
            ge     = trial >= {1'b0, w_bb[k]};
            n_rem  = ge ? diff[lfc_pkg::COUNT_W-1:0] : trial[lfc_pkg::COUNT_W-1:0];
            n_work = {w_work[k][N-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_adv) begin
                r_vld <= w_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem  <= n_rem;
                r_work <= n_work;
                r_bb   <= w_bb[k];
                r_ir   <= w_ir[k];
            end
        end

        assign w_vld[k+1]  = r_vld;
        assign w_rem[k+1]  = r_rem;
        assign w_work[k+1] = r_work;
        assign w_bb[k+1]   = r_bb;
        assign w_ir[k+1]   = r_ir;
    end

    assign o_valid = w_vld[N];
    assign o_quot  = w_work[N];
    assign o_bb    = w_bb[N];
    assign o_ir    = w_ir[N];

    // remainder out of the last step must be below a nonzero divisor
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[N] && (w_bb[N] != '0)) |-> (w_rem[N] < w_bb[N]))
        else $error("divider remainder not below divisor");

endmodule

### sv/lfc_lux.sv
// Segment select, coefficient multiply, clamp, round and saturate stages.
module lfc_lux (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  lfc_pkg::t_quot       i_quot,
    input  lfc_pkg::t_count      i_bb,
    input  lfc_pkg::t_count      i_ir,
    output logic                 o_valid,
    output lfc_pkg::t_lux        o_lux
);

    // stage 1: round the ratio and pick the segment
    logic [lfc_pkg::DIV_W:0] ratio_inc;
    lfc_pkg::t_quot          ratio;
    lfc_pkg::t_seg           n_s1_seg;

    logic                r_s1_vld;
    lfc_pkg::t_seg       r_s1_seg;
    lfc_pkg::t_count     r_s1_bb;
    lfc_pkg::t_count     r_s1_ir;

    always_comb begin
        ratio_inc = {1'b0, i_quot} + 1'b1;
        // zero broadband gives ratio 0 (divider output is meaningless then)
        ratio     = (i_bb == '0) ? '0 : ratio_inc[lfc_pkg::DIV_W:1];
        n_s1_seg  = lfc_pkg::pick_segment(ratio);
    end

    // stage 2: both products
    lfc_pkg::t_coef  coef_b;
    lfc_pkg::t_coef  coef_m;
    lfc_pkg::t_prod  n_s2_pos;
    lfc_pkg::t_prod  n_s2_neg;

    logic            r_s2_vld;
    lfc_pkg::t_prod  r_s2_pos;
    lfc_pkg::t_prod  r_s2_neg;
    lfc_pkg::t_count r_s2_bb;

    always_comb begin
        coef_b   = lfc_pkg::scale_coeff(lfc_pkg::SEG_B[r_s1_seg]);
        coef_m   = lfc_pkg::scale_coeff(lfc_pkg::SEG_M[r_s1_seg]);
        n_s2_pos = lfc_pkg::t_prod'(r_s1_bb) * lfc_pkg::t_prod'(coef_b);
        n_s2_neg = lfc_pkg::t_prod'(r_s1_ir) * lfc_pkg::t_prod'(coef_m);
    end

    // stage 3: clamp, round, scale down, saturate
    lfc_pkg::t_prod             diff;
    logic [lfc_pkg::SUM_W-1:0]  sum;
    logic [lfc_pkg::SUM_W-1:0]  shifted;
    lfc_pkg::t_lux              n_lux;

    logic          r_s3_vld;
    lfc_pkg::t_lux r_s3_lux;

    always_comb begin
        diff    = (r_s2_pos > r_s2_neg) ? (r_s2_pos - r_s2_neg) : '0;
        sum     = lfc_pkg::SUM_W'(diff)
                + (lfc_pkg::SUM_W'(1) << (lfc_pkg::LUX_FRAC_BITS - 1));
        shifted = sum >> lfc_pkg::LUX_FRAC_BITS;
        if (shifted > lfc_pkg::SUM_W'({lfc_pkg::LUX_W{1'b1}})) begin
            n_lux = '1;
        end else begin
            n_lux = shifted[lfc_pkg::LUX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (i_adv) begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_seg <= n_s1_seg;
            r_s1_bb  <= i_bb;
            r_s1_ir  <= i_ir;
            r_s2_pos <= n_s2_pos;
            r_s2_neg <= n_s2_neg;
            r_s2_bb  <= r_s1_bb;
            r_s3_lux <= n_lux;
        end
    end

    assign o_valid = r_s3_vld;
    assign o_lux   = r_s3_lux;

    // last segment carries zero coefficients
    a_last_seg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_s1_vld && (r_s1_seg == lfc_pkg::SEG_W'(lfc_pkg::SEGMENTS - 1)))
        |=> (r_s2_pos == '0) && (r_s2_neg == '0))
        else $error("last segment produced nonzero products");

    // zero broadband count never yields positive lux
    a_zero_bb_zero_lux: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && r_s2_vld && (r_s2_bb == '0)) |=> (r_s3_lux == '0))
        else $error("zero broadband gave nonzero lux");

endmodule

### sv/lux_from_two_channels.sv
// Top level of the two-channel lux calculator.
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one word per cycle while
//   o_in_ready is high: a broadband count and an infrared count. Output
//   channel (o_out_valid / i_out_ready) delivers one lux word per input
//   word, in order. Words pass through the pipelined restoring divider,
//   which forms the quotient bit by bit, then segment select, multiply,
//   and a round/saturate stage that is also the output register.
//   Throughput is one word per cycle unless the receiver stalls; the divider
//   pipeline sets that figure, with every stage fully registered.
//   Reset (i_rst_n low, synchronous) clears all valid bits; data registers
//   are not cleared. When the receiver stalls with a word on the output, the
//   whole pipeline holds and o_in_ready drops; empty output lets it advance.
//   There is no configuration and no state kept between words.
module lux_from_two_channels (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lfc_pkg::t_count      i_broadband_count,
    input  lfc_pkg::t_count      i_infrared_count,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lfc_pkg::t_lux        o_lux_value
);

    logic            adv;
    logic            div_vld;
    lfc_pkg::t_quot  div_quot;
    lfc_pkg::t_count div_bb;
    lfc_pkg::t_count div_ir;

    assign adv        = i_out_ready || !o_out_valid;
    assign o_in_ready = adv;

    lfc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_in_valid),
        .i_bb    (i_broadband_count),
        .i_ir    (i_infrared_count),
        .o_valid (div_vld),
        .o_quot  (div_quot),
        .o_bb    (div_bb),
        .o_ir    (div_ir)
    );

    lfc_lux u_lux (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (div_vld),
        .i_quot  (div_quot),
        .i_bb    (div_bb),
        .i_ir    (div_ir),
        .o_valid (o_out_valid),
        .o_lux   (o_lux_value)
    );

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

### sim/lux_from_two_channels_tb.sv
// Self-checking testbench for the two-channel lux calculator: directed probes, then random words.
module lux_from_two_channels_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef lfc_pkg::t_count t_count;
    typedef lfc_pkg::t_lux   t_lux;

    localparam int RATIO_FB      = lfc_pkg::RATIO_FRAC_BITS;
    localparam int LUX_FB        = lfc_pkg::LUX_FRAC_BITS;
    localparam int TBL_RATIO_FB  = 9;
    localparam int TBL_LUX_FB    = 14;
    localparam int NUM_SEG       = 8;
    localparam int PIPE_DEPTH    = lfc_pkg::DIV_W + 3;
    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_SHOWN     = 10;
    localparam int NUM_PHASES    = 5;
    localparam int NUM_PROBES    = 23;

    // T-package breakpoints (9 fraction bits), intercepts and slopes (14 fraction bits)
    localparam bit [9:0] BREAK_POINT [NUM_SEG] = '{
        10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a, 10'h29a
    };
    localparam bit [9:0] INTERCEPT [NUM_SEG] = '{
        10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000
    };
    localparam bit [9:0] SLOPE [NUM_SEG] = '{
        10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000
    };

    typedef struct packed {
        bit [15:0] broadband;
        bit [15:0] infrared;
        bit        known;
        bit [15:0] lux;
    } t_probe;

    // broadband 512 gives ratio = infrared count: hits each breakpoint, most also one past
    localparam t_probe PROBES [NUM_PROBES] = '{
        '{16'd0,     16'd0,     1'b1, 16'd0},
        '{16'd0,     16'd1,     1'b1, 16'd0},
        '{16'd0,     16'd65535, 1'b1, 16'd0},
        '{16'd1,     16'd0,     1'b1, 16'd0},
        '{16'd1,     16'd65535, 1'b1, 16'd0},
        '{16'd100,   16'd200,   1'b1, 16'd0},
        '{16'd65535, 16'd0,     1'b1, 16'd1992},
        '{16'd65535, 16'd65535, 1'b1, 16'd24},
        '{16'd65535, 16'd1,     1'b0, 16'd0},
        '{16'h5555,  16'h2aaa,  1'b0, 16'd0},
        '{16'haaaa,  16'h1555,  1'b0, 16'd0},
        '{16'd512,   16'd64,    1'b0, 16'd0},
        '{16'd512,   16'd65,    1'b0, 16'd0},
        '{16'd512,   16'd128,   1'b0, 16'd0},
        '{16'd512,   16'd129,   1'b0, 16'd0},
        '{16'd512,   16'd192,   1'b0, 16'd0},
        '{16'd512,   16'd193,   1'b0, 16'd0},
        '{16'd512,   16'd256,   1'b0, 16'd0},
        '{16'd512,   16'd257,   1'b0, 16'd0},
        '{16'd512,   16'd312,   1'b0, 16'd0},
        '{16'd512,   16'd410,   1'b0, 16'd0},
        '{16'd512,   16'd666,   1'b0, 16'd0},
        '{16'd512,   16'd667,   1'b1, 16'd0}
    };

    // per phase: sender idle %, receiver stall %, random words, long receiver hold-off
    localparam int PH_SEND_IDLE  [NUM_PHASES] = '{0, 75, 0, 24, 0};
    localparam int PH_RECV_STALL [NUM_PHASES] = '{0, 0, 75, 24, 0};
    localparam int PH_WORDS      [NUM_PHASES] = '{200, 150, 150, 200, 150};
    localparam bit PH_HOLD       [NUM_PHASES] = '{0, 0, 0, 0, 1};

    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_ready;
    t_count i_broadband_count;
    t_count i_infrared_count;
    logic   o_out_valid;
    logic   i_out_ready;
    t_lux   o_lux_value;

    t_lux   pending_lux [$];
    t_lux   next_lux;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     fault_count;
    int     shown_count;
    int     idle_cycles;
    int     hold_left;
    bit     hold_request;

    lux_from_two_channels i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_broadband_count(i_broadband_count),
        .i_infrared_count (i_infrared_count),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_lux_value      (o_lux_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_lux predict_lux(input t_count bb, input t_count ir);
        longint unsigned ch0, ch1, quot, ratio, b, m, pos, neg, diff, lux;
        int              seg;
        bit              found;
        ch0   = bb;
        ch1   = ir;
        ratio = 0;
        if (ch0 != 0) begin
            quot  = (ch1 << (RATIO_FB + 1)) / ch0;
            ratio = (quot + 1) >> 1;
        end
        seg   = NUM_SEG - 1;
        found = 1'b0;
        for (int i = 0; i < NUM_SEG - 1; i++) begin
            if (!found && ((ratio << TBL_RATIO_FB) <=
                           (longint'(BREAK_POINT[i]) << RATIO_FB))) begin
                seg   = i;
                found = 1'b1;
            end
        end
        b = INTERCEPT[seg];
        m = SLOPE[seg];
        if (LUX_FB >= TBL_LUX_FB) begin
            b = b << (LUX_FB - TBL_LUX_FB);
            m = m << (LUX_FB - TBL_LUX_FB);
        end else begin
            b = b >> (TBL_LUX_FB - LUX_FB);
            m = m >> (TBL_LUX_FB - LUX_FB);
        end
        pos  = ch0 * b;
        neg  = ch1 * m;
        diff = (pos > neg) ? (pos - neg) : 64'd0;
        lux  = (diff + (64'd1 << (LUX_FB - 1))) >> LUX_FB;
        if (lux > 64'hffff) begin
            lux = 64'hffff;
        end
        return t_lux'(lux);
    endfunction

    // holds valid and payload from a falling edge until the word is taken
    task automatic send_word(input t_count bb, input t_count ir, input t_lux lux);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        = 1'b1;
        i_broadband_count = bb;
        i_infrared_count  = ir;
        next_lux          = lux;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending_lux.size() != 0) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready = 1'b0;
        end else begin
            i_out_ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // scoreboard: queue each accepted word's lux, check each delivered word in order
    always @(posedge i_clk) begin
        t_lux want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                pending_lux.push_back(next_lux);
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_lux.size() == 0) begin
                    fault_count++;
                    if (shown_count < MAX_SHOWN) begin
                        shown_count++;
                        $display("%0t: unexpected lux word %0d", $realtime, o_lux_value);
                    end
                end else begin
                    want = pending_lux.pop_front();
                    if (o_lux_value !== want) begin
                        fault_count++;
                        if (shown_count < MAX_SHOWN) begin
                            shown_count++;
                            $display("%0t: lux mismatch: expected %0d, got %0d",
                                     $realtime, want, o_lux_value);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int     ch0;
        int     ch1;
        t_count bb;
        t_count ir;
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_broadband_count = '0;
        i_infrared_count  = '0;
        i_out_ready       = 1'b0;
        next_lux          = '0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        fault_count       = 0;
        shown_count       = 0;
        idle_cycles       = 0;
        hold_left         = 0;
        hold_request      = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int p = 0; p < NUM_PROBES; p++) begin
            send_word(PROBES[p].broadband, PROBES[p].infrared,
                      PROBES[p].known ? PROBES[p].lux :
                      predict_lux(PROBES[p].broadband, PROBES[p].infrared));
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            send_idle_pct  = PH_SEND_IDLE[ph];
            recv_stall_pct = PH_RECV_STALL[ph];
            if (PH_HOLD[ph]) begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < PH_WORDS[ph]; n++) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: begin
                        ch0 = $urandom_range(65535);
                        ch1 = $urandom_range(65535);
                    end
                    4, 5: begin
                        // ratio right around a breakpoint
                        ch0 = $urandom_range(65535, 1);
                        ch1 = ((ch0 * int'(BREAK_POINT[$urandom_range(NUM_SEG - 2)])) >> 9)
                              + int'($urandom_range(4)) - 2;
                        ch1 = (ch1 < 0) ? 0 : (ch1 > 65535) ? 65535 : ch1;
                    end
                    6: begin
                        ch0 = $urandom_range(15);
                        ch1 = $urandom_range(15);
                    end
                    7: begin
                        ch0 = $urandom_range(1) ? 0 : $urandom_range(65535);
                        ch1 = (ch0 == 0) ? $urandom_range(65535) : 0;
                    end
                    default: begin
                        ch0 = $urandom_range(65535);
                        ch1 = $urandom_range(ch0);
                    end
                endcase
                bb = t_count'(ch0);
                ir = t_count'(ch1);
                send_word(bb, ir, predict_lux(bb, ir));
            end
        end

        wait_drained();
        repeat (PIPE_DEPTH + 16) @(posedge i_clk);
        if (pending_lux.size() != 0) begin
            fault_count += pending_lux.size();
            $display("%0d expected lux words never arrived", pending_lux.size());
        end
        if (fault_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
